// ===== rtl/crtl_pkg.sv =====
package crtl_pkg;
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned XBits = $clog2(MaxWidth);
  localparam int unsigned YBits = $clog2(MaxHeight);
  localparam int unsigned AddrBits = XBits + YBits;
  localparam int unsigned Depth = MaxWidth * MaxHeight;

  typedef enum logic [2:0] {
    OP_FILL  = 3'd0,
    OP_CLEAR = 3'd1,
    OP_STROKE = 3'd2,
    OP_LINE  = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    REG_SURF_W = 3'd0,
    REG_SURF_H = 3'd1,
    REG_FILL   = 3'd2,
    REG_STROKE = 3'd3,
    REG_PEN    = 3'd4
  } reg_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_BOX_SETUP,
    ST_BOX_RUN,
    ST_LINE_STEP,
    ST_READ_WAIT,
    ST_READ_DATA,
    ST_OUT
  } state_e;
endpackage

// ===== rtl/crtl_ram.sv =====
module crtl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/clipped_rect_and_thick_line_raster_core.sv =====
// Fill and clear set up the clipped box and paint it; stroke paints four clipped bands
// in turn; line paints the clipped pen square at each point, then steps; read waits for
// the frame store and captures the pixel; rejected strokes and unused codes go straight
// to the result, held until taken before the next command is accepted; one command is
// in flight at a time. After reset the frame store is cleared one pixel per cycle before
// the first command is accepted; configuration writes are taken throughout.
module clipped_rect_and_thick_line_raster_core import crtl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation_i,
  input  logic signed [15:0] first_x_i,
  input  logic signed [15:0] first_y_i,
  input  logic signed [15:0] second_x_i,
  input  logic signed [15:0] second_y_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status_o,
  output logic [31:0] pixel_value_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  state_e state_q, state_d;

  logic [8:0]  surf_w_q, surf_h_q;
  logic [31:0] fill_q, stroke_q;
  logic [5:0]  pen_q;

  // Command registers.
  op_e         op_q;
  logic signed [17:0] ax_q, ay_q, bx_q, by_q;
  logic [1:0]  band_q;
  // Box being painted, and its clipped bounds.
  logic signed [17:0] bxs_q, bys_q, bw_q, bh_q;
  logic [XBits:0] left_q, right_q, col_q;
  logic [YBits:0] bot_q, row_q;
  logic [31:0] color_q;
  // Line state.
  logic signed [17:0] lx_q, ly_q, dx_q, dy_q;
  logic signed [19:0] err_q;
  logic        sx_q, sy_q;
  logic        status_q;
  logic [31:0] pix_q;
  logic [AddrBits-1:0] init_q;

  logic we;
  logic [AddrBits-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;

  crtl_ram #(.Width(32), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign cfg_ready = 1'b1;

  logic [8:0] eff_w, eff_h;
  logic [5:0] pen;
  logic signed [17:0] rad;
  always_comb begin
    eff_w = (surf_w_q > 9'(MaxWidth)) ? 9'(MaxWidth) : surf_w_q;
    eff_h = (surf_h_q > 9'(MaxHeight)) ? 9'(MaxHeight) : surf_h_q;
    pen = (pen_q == 6'd0) ? 6'd1 : ((pen_q > 6'd32) ? 6'd32 : pen_q);
    rad = 18'((pen - 6'd1) >> 1);
  end

  // Clip the pending box.
  logic signed [17:0] c_left, c_top, c_right, c_bot;
  logic box_ok;
  always_comb begin
    c_left = (bxs_q > 0) ? bxs_q : 18'sd0;
    c_top = (bys_q > 0) ? bys_q : 18'sd0;
    c_right = (bxs_q + bw_q < $signed({9'd0, eff_w})) ? bxs_q + bw_q
                                                     : $signed({9'd0, eff_w});
    c_bot = (bys_q + bh_q < $signed({9'd0, eff_h})) ? bys_q + bh_q
                                                   : $signed({9'd0, eff_h});
    box_ok = (bw_q > 0) && (bh_q > 0) && (eff_w != 9'd0) && (eff_h != 9'd0) &&
             (c_right > c_left) && (c_bot > c_top);
  end

  logic line_end;
  logic signed [19:0] e2;
  assign line_end = (lx_q == bx_q) && (ly_q == by_q);
  assign e2 = err_q <<< 1;

  logic signed [17:0] step_x, step_y;
  logic signed [19:0] step_err;
  always_comb begin
    step_x = lx_q;
    step_y = ly_q;
    step_err = err_q;
    if (e2 >= 20'(dy_q)) begin
      step_err = step_err + 20'(dy_q);
      step_x = sx_q ? lx_q + 18'sd1 : lx_q - 18'sd1;
    end
    if (e2 <= 20'(dx_q)) begin
      step_err = step_err + 20'(dx_q);
      step_y = sy_q ? ly_q + 18'sd1 : ly_q - 18'sd1;
    end
  end

  logic last_col, last_row;
  assign last_col = (col_q + 1'b1) == right_q;
  assign last_row = (row_q + 1'b1) == bot_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: if (init_q == AddrBits'(Depth - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          case (operation_i)
            OP_FILL, OP_CLEAR: state_d = ST_BOX_SETUP;
            OP_STROKE: state_d = (second_x_i <= 0 || second_y_i <= 0) ? ST_OUT
                                                                     : ST_BOX_SETUP;
            OP_LINE: state_d = ST_BOX_SETUP;
            OP_READ: state_d = ST_READ_WAIT;
            default: state_d = ST_OUT;
          endcase
        end
      end
      ST_BOX_SETUP: begin
        if (box_ok) state_d = ST_BOX_RUN;
        else if (op_q == OP_LINE) state_d = ST_LINE_STEP;
        else if (op_q == OP_STROKE && band_q != 2'd3) state_d = ST_BOX_SETUP;
        else state_d = ST_OUT;
      end
      ST_BOX_RUN: begin
        if (last_col && last_row) begin
          if (op_q == OP_LINE) state_d = ST_LINE_STEP;
          else if (op_q == OP_STROKE && band_q != 2'd3) state_d = ST_BOX_SETUP;
          else state_d = ST_OUT;
        end
      end
      ST_LINE_STEP: state_d = line_end ? ST_OUT : ST_BOX_SETUP;
      ST_READ_WAIT: state_d = ST_READ_DATA;
      ST_READ_DATA: state_d = ST_OUT;
      ST_OUT: if (!out_stall) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_q != ST_IDLE);
    out_valid = (state_q == ST_OUT);
    we = (state_q == ST_INIT) || (state_q == ST_BOX_RUN);
    waddr = (state_q == ST_INIT) ? init_q
                                 : {row_q[YBits-1:0], col_q[XBits-1:0]};
    wdata = (state_q == ST_INIT) ? 32'd0 : color_q;
    raddr = {ay_q[YBits-1:0], ax_q[XBits-1:0]};
  end
  assign status_o = status_q;
  assign pixel_value_o = pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      init_q <= '0;
      surf_w_q <= 9'd256;
      surf_h_q <= 9'd256;
      fill_q <= 32'd255;
      stroke_q <= 32'd255;
      pen_q <= 6'd1;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT) init_q <= init_q + 1'b1;
      if (cfg_valid) begin
        case (cfg_index_i)
          REG_SURF_W: surf_w_q <= cfg_data_i[8:0];
          REG_SURF_H: surf_h_q <= cfg_data_i[8:0];
          REG_FILL:   fill_q <= cfg_data_i;
          REG_STROKE: stroke_q <= cfg_data_i;
          REG_PEN:    pen_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
    end
  end

  // Latches commands, walks each box (per stroke band and line point), steps lines, captures read data.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (in_valid) begin
        op_q <= op_e'(operation_i);
        ax_q <= 18'(first_x_i); ay_q <= 18'(first_y_i);
        bx_q <= 18'(second_x_i); by_q <= 18'(second_y_i);
        lx_q <= 18'(first_x_i); ly_q <= 18'(first_y_i);
        dx_q <= (second_x_i > first_x_i) ? 18'(second_x_i) - 18'(first_x_i)
                                         : 18'(first_x_i) - 18'(second_x_i);
        dy_q <= (second_y_i > first_y_i) ? 18'(first_y_i) - 18'(second_y_i)
                                         : 18'(second_y_i) - 18'(first_y_i);
        err_q <= (second_x_i > first_x_i ? 20'(second_x_i) - 20'(first_x_i)
                                         : 20'(first_x_i) - 20'(second_x_i)) +
                 (second_y_i > first_y_i ? 20'(first_y_i) - 20'(second_y_i)
                                         : 20'(second_y_i) - 20'(first_y_i));
        sx_q <= first_x_i < second_x_i;
        sy_q <= first_y_i < second_y_i;
        band_q <= 2'd0;
        status_q <= (operation_i == OP_STROKE) && (second_x_i <= 0 || second_y_i <= 0);
        pix_q <= '0;
        color_q <= (operation_i == OP_FILL) ? fill_q :
                   (operation_i == OP_CLEAR) ? 32'd0 : stroke_q;
        // A line starts with the pen square around its first point.
        bxs_q <= (operation_i == OP_LINE) ? 18'(first_x_i) - rad : 18'(first_x_i);
        bys_q <= (operation_i == OP_LINE) ? 18'(first_y_i) - rad : 18'(first_y_i);
        bw_q <= (operation_i == OP_LINE) ? 18'(pen) : 18'(second_x_i);
        bh_q <= (operation_i inside {OP_STROKE, OP_LINE}) ? 18'(pen) : 18'(second_y_i);
      end
      ST_BOX_SETUP: begin
        left_q <= c_left[XBits:0]; col_q <= c_left[XBits:0];
        right_q <= c_right[XBits:0];
        row_q <= c_top[YBits:0]; bot_q <= c_bot[YBits:0];
        if (!box_ok && op_q == OP_STROKE && band_q != 2'd3) begin
          band_q <= band_q + 1'b1;
          case (band_q)
            2'd0: begin bxs_q <= ax_q; bys_q <= ay_q + by_q - 18'(pen);
                        bw_q <= bx_q; bh_q <= 18'(pen); end
            2'd1: begin bxs_q <= ax_q; bys_q <= ay_q; bw_q <= 18'(pen); bh_q <= by_q; end
            default: begin bxs_q <= ax_q + bx_q - 18'(pen); bys_q <= ay_q;
                           bw_q <= 18'(pen); bh_q <= by_q; end
          endcase
        end
      end
      ST_BOX_RUN: begin
        if (last_col) begin
          col_q <= left_q; row_q <= row_q + 1'b1;
          if (last_row && op_q == OP_STROKE && band_q != 2'd3) begin
            band_q <= band_q + 1'b1;
            case (band_q)
              2'd0: begin bxs_q <= ax_q; bys_q <= ay_q + by_q - 18'(pen);
                          bw_q <= bx_q; bh_q <= 18'(pen); end
              2'd1: begin bxs_q <= ax_q; bys_q <= ay_q; bw_q <= 18'(pen); bh_q <= by_q; end
              default: begin bxs_q <= ax_q + bx_q - 18'(pen); bys_q <= ay_q;
                             bw_q <= 18'(pen); bh_q <= by_q; end
            endcase
          end
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      ST_LINE_STEP: if (!line_end) begin
        lx_q <= step_x; ly_q <= step_y; err_q <= step_err;
        bxs_q <= step_x - rad; bys_q <= step_y - rad;
      end
      ST_READ_WAIT: ;
      ST_READ_DATA: begin
        if (ax_q >= 0 && ay_q >= 0 && ax_q < $signed({9'd0, eff_w}) &&
            ay_q < $signed({9'd0, eff_h})) pix_q <= rdata;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_OUT) |-> !we) else $error("write while idle");
  a_reject_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && status_o) |-> (pixel_value_o == 32'd0)) else $error("bad reject");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> (out_valid && $stable(pixel_value_o)))
    else $error("result lost");
`endif
endmodule
